FILE: sv/tsvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsvs_pkg: shared types and constants of the threshold stepper valve sequencer
// Holds the configuration layout, the transaction structs and the coil table.
// ----------------------------------------------------------------------------
package tsvs_pkg;

    // Number of passes over the four coil patterns in one burst (1 to 8).
    localparam int ROUNDS  = 2;
    localparam int ROUND_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP_LOW  = 3'd0,
        REG_TEMP_HIGH = 3'd1,
        REG_HUM_LOW   = 3'd2,
        REG_HUM_HIGH  = 3'd3,
        REG_CO2_LIMIT = 3'd4,
        REG_PHASE     = 3'd5,
        REG_GAP       = 3'd6,
        REG_BURSTS    = 3'd7
    } t_cfg_reg;

    // Reset values of the configuration registers.
    localparam logic signed [7:0] RST_TEMP_LOW  = 8'sd18;
    localparam logic signed [7:0] RST_TEMP_HIGH = 8'sd22;
    localparam logic [6:0]        RST_HUM_LOW   = 7'd35;
    localparam logic [6:0]        RST_HUM_HIGH  = 7'd60;
    localparam logic [13:0]       RST_CO2_LIMIT = 14'd800;
    localparam logic [15:0]       RST_PHASE     = 16'd50;
    localparam logic [15:0]       RST_GAP       = 16'd10;
    localparam logic [7:0]        RST_BURSTS    = 8'd130;

    // Operation codes of an input item.
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic signed [7:0] temp_low;
        logic signed [7:0] temp_high;
        logic [6:0]        hum_low;
        logic [6:0]        hum_high;
        logic [13:0]       co2_limit;
        logic [15:0]       phase_ticks;
        logic [15:0]       gap_ticks;
        logic [7:0]        burst_count;
    } t_cfg;

    typedef struct packed {
        logic              operation;
        logic signed [11:0] temperature;
        logic [10:0]       humidity;
        logic [13:0]       co2_level;
    } t_item;

    typedef struct packed {
        logic [3:0] coils;
        logic       too_cold;
        logic       too_hot;
        logic       too_dry;
        logic       too_humid;
        logic       valve_busy;
        logic       opening;
        logic       sample_dropped;
    } t_result;

    // Full-step coil pattern in the close direction; open walks it backwards.
    function automatic logic [3:0] coil_pattern(input logic [1:0] idx, input logic open);
        logic [1:0] p;
        logic [3:0] pat;
        p = open ? (2'd3 - idx) : idx;
        case (p)
            2'd0:    pat = 4'h3;
            2'd1:    pat = 4'h6;
            2'd2:    pat = 4'hC;
            default: pat = 4'h9;
        endcase
        return pat;
    endfunction

endpackage

FILE: sv/threshold_stepper_valve_sequencer_unit.sv
`timescale 1ns / 1ps
// A transaction is loaded into the input register when it is accepted and into
// the result register when it advances; a stall on the output holds it back.
// Throughput: one transaction per cycle while the output is not stalled; the
// one-pass update of the run state between the two registers sets that rate.
// Reset: synchronous, active low; configuration returns to its defaults and
// the sequencer goes idle with all flags clear; the result payload is not reset.
// ----------------------------------------------------------------------------
// threshold_stepper_valve_sequencer_unit: top level
// Input register, single-pass sequencer core and result register with a
// valid/stall handshake on both channels, plus the configuration port.
// ----------------------------------------------------------------------------
module threshold_stepper_valve_sequencer_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_operation,
    input  logic signed [11:0]                i_temperature,
    input  logic [10:0]                       i_humidity,
    input  logic [13:0]                       i_co2_level,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [3:0]                        o_coils,
    output logic                              o_too_cold,
    output logic                              o_too_hot,
    output logic                              o_too_dry,
    output logic                              o_too_humid,
    output logic                              o_valve_busy,
    output logic                              o_opening,
    output logic                              o_sample_dropped,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tsvs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tsvs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    tsvs_pkg::t_cfg    cfg;
    tsvs_pkg::t_item   r_item;
    tsvs_pkg::t_result result;
    tsvs_pkg::t_result r_result;
    logic              r_in_valid;
    logic              r_out_valid;
    logic              advance;
    logic              in_accept;

    // The staged transaction moves on when the result register is free.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    tsvs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    tsvs_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (advance),
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.operation   <= i_operation;
            r_item.temperature <= i_temperature;
            r_item.humidity    <= i_humidity;
            r_item.co2_level   <= i_co2_level;
        end
    end

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_coils          = r_result.coils;
    assign o_too_cold       = r_result.too_cold;
    assign o_too_hot        = r_result.too_hot;
    assign o_too_dry        = r_result.too_dry;
    assign o_too_humid      = r_result.too_humid;
    assign o_valve_busy     = r_result.valve_busy;
    assign o_opening        = r_result.opening;
    assign o_sample_dropped = r_result.sample_dropped;

endmodule

FILE: sv/tsvs_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsvs_cfg: configuration register file
// Eight registers written through a valid/ready channel that is always ready.
// ----------------------------------------------------------------------------
module tsvs_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [tsvs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tsvs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                               o_cfg_ready,
    output tsvs_pkg::t_cfg                     o_cfg
);

    tsvs_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register writes; each register keeps the low bits of the write data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.temp_low    <= tsvs_pkg::RST_TEMP_LOW;
            r_cfg.temp_high   <= tsvs_pkg::RST_TEMP_HIGH;
            r_cfg.hum_low     <= tsvs_pkg::RST_HUM_LOW;
            r_cfg.hum_high    <= tsvs_pkg::RST_HUM_HIGH;
            r_cfg.co2_limit   <= tsvs_pkg::RST_CO2_LIMIT;
            r_cfg.phase_ticks <= tsvs_pkg::RST_PHASE;
            r_cfg.gap_ticks   <= tsvs_pkg::RST_GAP;
            r_cfg.burst_count <= tsvs_pkg::RST_BURSTS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (tsvs_pkg::t_cfg_reg'(i_cfg_index))
                tsvs_pkg::REG_TEMP_LOW:  r_cfg.temp_low    <= signed'(i_cfg_data[7:0]);
                tsvs_pkg::REG_TEMP_HIGH: r_cfg.temp_high   <= signed'(i_cfg_data[7:0]);
                tsvs_pkg::REG_HUM_LOW:   r_cfg.hum_low     <= i_cfg_data[6:0];
                tsvs_pkg::REG_HUM_HIGH:  r_cfg.hum_high    <= i_cfg_data[6:0];
                tsvs_pkg::REG_CO2_LIMIT: r_cfg.co2_limit   <= i_cfg_data[13:0];
                tsvs_pkg::REG_PHASE:     r_cfg.phase_ticks <= i_cfg_data;
                tsvs_pkg::REG_GAP:       r_cfg.gap_ticks   <= i_cfg_data;
                tsvs_pkg::REG_BURSTS:    r_cfg.burst_count <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: sv/tsvs_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsvs_core: threshold compare and valve run sequencer
// Computes the next run state and the result of one item in a single pass;
// the state registers advance when the top level commits the item.
// ----------------------------------------------------------------------------
module tsvs_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_commit,
    input  tsvs_pkg::t_item     i_item,
    input  tsvs_pkg::t_cfg      i_cfg,
    output tsvs_pkg::t_result   o_result
);

    logic                         r_active, n_active;
    logic                         r_dir, n_dir;
    logic                         r_in_gap, n_in_gap;
    logic [7:0]                   r_bursts, n_bursts;
    logic [1:0]                   r_phase, n_phase;
    logic [tsvs_pkg::ROUND_W-1:0] r_round, n_round;
    logic [15:0]                  r_ticks, n_ticks;
    logic [3:0]                   r_flags, n_flags;
    logic                         dropped;

    // Next state for one tick or one sample.
    always_comb begin
        logic [15:0]       phase_load;
        logic [15:0]       dec;
        logic [7:0]        bl_dec;
        logic signed [11:0] t_lo;
        logic signed [11:0] t_hi;
        logic [10:0]       h_lo;
        logic [10:0]       h_hi;

        phase_load = (i_cfg.phase_ticks == 16'd0) ? 16'd1 : i_cfg.phase_ticks;
        dec        = (r_ticks != 16'd0) ? (r_ticks - 16'd1) : 16'd0;
        bl_dec     = r_bursts - 8'd1;
        t_lo       = signed'({i_cfg.temp_low, 4'b0000});
        t_hi       = signed'({i_cfg.temp_high, 4'b0000});
        h_lo       = {i_cfg.hum_low, 4'b0000};
        h_hi       = {i_cfg.hum_high, 4'b0000};

        n_active = r_active;
        n_dir    = r_dir;
        n_in_gap = r_in_gap;
        n_bursts = r_bursts;
        n_phase  = r_phase;
        n_round  = r_round;
        n_ticks  = r_ticks;
        n_flags  = r_flags;
        dropped  = 1'b0;

        if (i_item.operation == tsvs_pkg::OP_TICK) begin
            if (r_active) begin
                n_ticks = dec;
                if (dec == 16'd0) begin
                    if (!r_in_gap && r_phase != 2'd3) begin
                        n_phase = r_phase + 2'd1;
                        n_ticks = phase_load;
                    end else if (!r_in_gap &&
                                 r_round != tsvs_pkg::ROUND_W'(tsvs_pkg::ROUNDS - 1)) begin
                        n_phase = 2'd0;
                        n_round = r_round + tsvs_pkg::ROUND_W'(1);
                        n_ticks = phase_load;
                    end else if (!r_in_gap && i_cfg.gap_ticks != 16'd0) begin
                        n_in_gap = 1'b1;
                        n_ticks  = i_cfg.gap_ticks;
                    end else begin
                        // End of burst: start the next one or finish the run.
                        n_bursts = bl_dec;
                        n_phase  = 2'd0;
                        n_round  = '0;
                        n_in_gap = 1'b0;
                        if (bl_dec == 8'd0) begin
                            n_active = 1'b0;
                            n_ticks  = 16'd0;
                        end else begin
                            n_ticks = phase_load;
                        end
                    end
                end
            end
        end else if (r_active) begin
            dropped = 1'b1;
        end else begin
            n_flags[0] = i_item.temperature < t_lo;
            n_flags[1] = i_item.temperature > t_hi;
            n_flags[2] = i_item.humidity < h_lo;
            n_flags[3] = i_item.humidity > h_hi;
            n_dir      = i_item.co2_level > i_cfg.co2_limit;
            if (i_cfg.burst_count != 8'd0) begin
                n_active = 1'b1;
                n_bursts = i_cfg.burst_count;
                n_phase  = 2'd0;
                n_round  = '0;
                n_in_gap = 1'b0;
                n_ticks  = phase_load;
            end
        end
    end

    // Result fields come from the state after this item.
    always_comb begin
        o_result.coils          = (n_active && !n_in_gap) ?
                                  tsvs_pkg::coil_pattern(n_phase, n_dir) : 4'h0;
        o_result.too_cold       = n_flags[0];
        o_result.too_hot        = n_flags[1];
        o_result.too_dry        = n_flags[2];
        o_result.too_humid      = n_flags[3];
        o_result.valve_busy     = n_active;
        o_result.opening        = n_dir;
        o_result.sample_dropped = dropped;
    end

    // Run state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_dir    <= 1'b0;
            r_in_gap <= 1'b0;
            r_bursts <= 8'd0;
            r_phase  <= 2'd0;
            r_round  <= '0;
            r_ticks  <= 16'd0;
            r_flags  <= 4'd0;
        end else if (i_commit) begin
            r_active <= n_active;
            r_dir    <= n_dir;
            r_in_gap <= n_in_gap;
            r_bursts <= n_bursts;
            r_phase  <= n_phase;
            r_round  <= n_round;
            r_ticks  <= n_ticks;
            r_flags  <= n_flags;
        end
    end

`ifndef ASSERT_OFF
    // An idle sequencer holds no pending count and is not in a gap.
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_ticks == 16'd0 && !r_in_gap && r_phase == 2'd0))
        else $error("idle sequencer holds stale run state");

    // A running sequencer always has a burst left and a nonzero count.
    a_run_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_bursts != 8'd0 && r_ticks != 16'd0))
        else $error("active run with empty burst or tick count");

    // A committed sample that was dropped leaves flags and direction alone.
    a_drop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_commit && dropped) |=> ($stable(r_flags) && $stable(r_dir) && r_active))
        else $error("dropped sample changed the sequencer");
`endif

endmodule
